// ===== hw/rtl/fisa_pkg.sv =====
`timescale 1ns / 1ps

package fisa_pkg;

    // field widths
    localparam int FUNC_W     = 2;
    localparam int IDX_W      = 10;
    localparam int ADDR_W     = 26;
    localparam int STATUS_W   = 2;
    localparam int CNT_W      = 11;
    localparam int BYTES_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // request function codes
    localparam logic [FUNC_W-1:0] FUNC_OBTAIN   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FREE_ALL = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_ACCESS   = 2'd3;

    // response status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_BYTES = 1'd1;

    // configuration reset values
    localparam logic [CNT_W-1:0]   POOL_SIZE_RESET  = 11'd1024;
    localparam logic [BYTES_W-1:0] SLOT_BYTES_RESET = 16'd64;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [IDX_W-1:0]  slot_index;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0]    granted_index;
        logic [ADDR_W-1:0]   slot_address;
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    in_use_count;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic decide;
        logic fill_step;
        logic load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic free_all;
        logic fill_done;
        logic out_free;
    } sts_t;

endpackage

// ===== hw/rtl/fisa_ram.sv =====
`timescale 1ns / 1ps

module fisa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/fisa_dp.sv =====
`timescale 1ns / 1ps

module fisa_dp #(
    parameter int POOL_DEPTH = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fisa_pkg::cmd_t                      cmd,
    output fisa_pkg::sts_t                      sts,
    input  fisa_pkg::req_t                      req,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output fisa_pkg::rsp_t                      rsp,
    input  logic                                cfg_valid,
    input  logic [fisa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fisa_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // indices beyond what the size register can reach are never used
    localparam int MEM_DEPTH = (POOL_DEPTH > 2048) ? 2048 : POOL_DEPTH;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int CW        = AW + 1;
    localparam int PW        = AW + fisa_pkg::BYTES_W;
    localparam logic [fisa_pkg::CNT_W:0] DEPTH_CAP = (fisa_pkg::CNT_W + 1)'(MEM_DEPTH);

    localparam int CNT_W  = fisa_pkg::CNT_W;
    localparam int IDX_W  = fisa_pkg::IDX_W;
    localparam int ADDR_W = fisa_pkg::ADDR_W;

    // configuration
    logic [CNT_W-1:0]             pool_size_reg;
    logic [fisa_pkg::BYTES_W-1:0] slot_bytes_reg;

    // stack state and request context
    logic [CNT_W-1:0]              top_reg, top_next;
    fisa_pkg::req_t                req_reg;
    logic [AW-1:0]                 oper_reg, oper_next;
    logic [IDX_W-1:0]              granted_reg, granted_next;
    logic [fisa_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [CW-1:0]                 fill_cnt_reg;
    logic [CW-1:0]                 fill_lim_reg;
    logic                          rsp_valid_reg;
    fisa_pkg::rsp_t                rsp_reg;

    logic [CNT_W-1:0] live_size;
    logic [CNT_W-1:0] top_dec;
    logic             idx_ok;
    logic             push_ok;
    logic             fill_done;
    logic             out_free;
    logic             ram_we;
    logic [AW-1:0]    ram_addr;
    logic [AW-1:0]    ram_wdata;
    logic [AW-1:0]    ram_rdata;
    logic [PW-1:0]    prod;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_size_reg  <= fisa_pkg::POOL_SIZE_RESET;
            slot_bytes_reg <= fisa_pkg::SLOT_BYTES_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                fisa_pkg::REG_POOL_SIZE:  pool_size_reg  <= cfg_data[CNT_W-1:0];
                fisa_pkg::REG_SLOT_BYTES: slot_bytes_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // effective pool size, saturated to the stack depth
    assign live_size = ({1'b0, pool_size_reg} > DEPTH_CAP) ? DEPTH_CAP[CNT_W-1:0]
                                                            : pool_size_reg;
    assign top_dec   = top_reg - CNT_W'(1);
    assign idx_ok    = {1'b0, req_reg.slot_index} < live_size;
    assign fill_done = fill_cnt_reg >= fill_lim_reg;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    // decide outcome of the held request, obtain taking the popped entry
    always_comb
    begin
        top_next     = top_reg;
        oper_next    = '0;
        granted_next = req_reg.slot_index;
        status_next  = fisa_pkg::ST_OK;
        push_ok      = 1'b0;
        case (req_reg.func)
            fisa_pkg::FUNC_OBTAIN:
            begin
                if (top_reg < live_size)
                begin
                    top_next     = top_reg + CNT_W'(1);
                    oper_next    = ram_rdata;
                    granted_next = IDX_W'(ram_rdata);
                end
                else
                begin
                    status_next = fisa_pkg::ST_EXHAUSTED;
                end
            end
            fisa_pkg::FUNC_RELEASE:
            begin
                if (!idx_ok)
                begin
                    status_next = fisa_pkg::ST_INVALID;
                end
                else if (top_reg == '0)
                begin
                    status_next = fisa_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    top_next  = top_dec;
                    oper_next = AW'(req_reg.slot_index);
                    push_ok   = 1'b1;
                end
            end
            fisa_pkg::FUNC_FREE_ALL:
            begin
                top_next = '0;
            end
            fisa_pkg::FUNC_ACCESS:
            begin
                if (!idx_ok)
                begin
                    status_next = fisa_pkg::ST_INVALID;
                end
                else
                begin
                    oper_next = AW'(req_reg.slot_index);
                end
            end
            default:
            begin
                status_next = fisa_pkg::ST_INVALID;
            end
        endcase
    end

    // stack memory port: refill sweep, push on release, else read at top
    always_comb
    begin
        ram_we    = (cmd.fill_step && !fill_done) || (cmd.decide && push_ok);
        ram_wdata = AW'(req_reg.slot_index);
        if (cmd.fill_step)
        begin
            ram_addr  = fill_cnt_reg[AW-1:0];
            ram_wdata = fill_cnt_reg[AW-1:0];
        end
        else if (cmd.decide)
        begin
            ram_addr = top_dec[AW-1:0];
        end
        else
        begin
            ram_addr = top_reg[AW-1:0];
        end
    end

    fisa_ram #(
        .WIDTH (AW),
        .DEPTH (MEM_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // request context and stack pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg      <= '0;
            fill_cnt_reg <= '0;
            fill_lim_reg <= CW'(MEM_DEPTH);
        end
        else
        begin
            if (cmd.decide)
            begin
                top_reg <= top_next;
                if (req_reg.func == fisa_pkg::FUNC_FREE_ALL)
                begin
                    fill_cnt_reg <= '0;
                    fill_lim_reg <= CW'(live_size);
                end
            end
            if (cmd.fill_step && !fill_done)
            begin
                fill_cnt_reg <= fill_cnt_reg + CW'(1);
            end
        end
    end

    // payload holding registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
        if (cmd.decide)
        begin
            oper_reg    <= oper_next;
            granted_reg <= granted_next;
            status_reg  <= status_next;
        end
    end

    // slot address, operand is zero when no address is due
    assign prod = PW'(oper_reg) * PW'(slot_bytes_reg);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rsp_reg.granted_index <= granted_reg;
            rsp_reg.slot_address  <= ADDR_W'(prod);
            rsp_reg.status        <= status_reg;
            rsp_reg.in_use_count  <= top_reg;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign rsp           = rsp_reg;
    assign sts.free_all  = req_reg.func == fisa_pkg::FUNC_FREE_ALL;
    assign sts.fill_done = fill_done;
    assign sts.out_free  = out_free;

    // a failed request never carries an address
    a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.status != fisa_pkg::ST_OK) |-> rsp_reg.slot_address == '0)
        else $error("failed response carries an address");

    // stack pointer stays within the stack
    a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, top_reg} <= DEPTH_CAP)
        else $error("stack pointer beyond stack depth");

    // a new response only appears after a load command
    a_rsp_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(cmd.load))
        else $error("response valid without load");

endmodule

// ===== hw/rtl/fisa_ctrl.sv =====
`timescale 1ns / 1ps

module fisa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    output fisa_pkg::cmd_t cmd,
    input  fisa_pkg::sts_t sts
);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_LOOK = 3'd2;
    localparam logic [2:0] S_FILL = 3'd3;
    localparam logic [2:0] S_LOAD = 3'd4;

    logic [2:0] state_reg, state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                if (sts.fill_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = sts.free_all ? S_FILL : S_LOAD;
            end
            S_FILL:
            begin
                if (sts.fill_done)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // commands
    assign req_stall     = state_reg != S_IDLE;
    assign cmd.capture   = (state_reg == S_IDLE) && req_valid;
    assign cmd.decide    = state_reg == S_LOOK;
    assign cmd.fill_step = (state_reg == S_INIT) || (state_reg == S_FILL);
    assign cmd.load      = (state_reg == S_LOAD) && sts.out_free;

    // lookup always follows an accepted request
    a_look_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOK) |-> ($past(state_reg) == S_IDLE))
        else $error("lookup without accepted request");

    // refill sweep runs to its end
    a_fill_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL && !sts.fill_done) |=> (state_reg == S_FILL))
        else $error("refill left early");

    // at most one command at a time
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.decide, cmd.fill_step, cmd.load}))
        else $error("overlapping commands");

endmodule

// ===== hw/rtl/free_index_stack_allocator.sv =====
`timescale 1ns / 1ps

// channel  | signals                       | direction | transfer
// ---------+-------------------------------+-----------+---------------------
// request  | req_valid, req_stall, req     | in        | valid && !stall
// response | rsp_valid, rsp_stall, rsp     | out       | valid && !stall
// config   | cfg_valid, cfg_ready,         | in        | valid && ready
//          | cfg_index, cfg_data           |           |
//
// one request at a time: accept, stack lookup, output load
// the single-port stack memory with registered read sets the lookup step
// free all adds a refill sweep over the effective pool size, one stack entry per cycle
// after reset the stack is swept to identity order over min(POOL_DEPTH, 2048)
// entries with requests stalled; config writes are always taken
// the response register holds while rsp_stall is high; a new request is then
// accepted and worked up to the load, which waits for the register to free

module free_index_stack_allocator #(
    parameter int POOL_DEPTH = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  fisa_pkg::req_t                      req,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output fisa_pkg::rsp_t                      rsp,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fisa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fisa_pkg::CFG_DATA_W-1:0]     cfg_data
);

    fisa_pkg::cmd_t cmd;
    fisa_pkg::sts_t sts;

    // config registers accept in any cycle
    assign cfg_ready = 1'b1;

    fisa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    fisa_dp #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
